FILE: hdl/pcmfade_pkg.sv
// pcmfade_pkg: widths, register codes and shared types of the fade-in streamer
// no dependencies; imported by every module and interface of the block
package pcmfade_pkg;

   // sample position counter width (16 to 32)
   localparam int POS_BITS  = 23;
   // clip and fade length register width
   localparam int LEN_BITS  = 23;
   // compare width covering both position and lengths
   localparam int CMP_BITS  = (POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS;
   localparam int CODE_BITS = 12;
   localparam int WORD_BITS = 16;
   localparam logic [CODE_BITS-1:0] MID_CODE = 12'd2048;

   // fade divider: quotient stays below 2^(CODE_BITS-1)+1, one bit a step
   localparam int DIV_STEPS = CODE_BITS;
   localparam int CNT_BITS  = $clog2(DIV_STEPS);
   localparam int DVS_BITS  = LEN_BITS + DIV_STEPS - 1;
   localparam int DIV_BITS  = LEN_BITS + CODE_BITS;

   // configuration port
   localparam int DATA_BITS = 32;
   localparam int ADDR_BITS = 4;
   localparam logic [1:0] REG_FORMAT = 2'd0;
   localparam logic [1:0] REG_CLIP   = 2'd1;
   localparam logic [1:0] REG_FADE   = 2'd2;

   // field codes
   localparam logic FMT_U8    = 1'b0;
   localparam logic FMT_S16   = 1'b1;
   localparam logic CMD_NEXT  = 1'b0;
   localparam logic CMD_START = 1'b1;

   typedef struct packed {
      logic                sample_format;
      logic [LEN_BITS-1:0] clip_samples;
      logic [LEN_BITS-1:0] fade_samples;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic mul_go;
      logic div_step;
      logic fix;
      logic load_out;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fade_go;
   } dp_stat_type;

endpackage

FILE: hdl/pcmfade_if.sv
// pcmfade_req_if / pcmfade_rsp_if: valid-ready channels of the fade-in streamer
// depends on pcmfade_pkg
interface pcmfade_req_if import pcmfade_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [WORD_BITS-1:0] sample_word;

   modport source (output valid, output command, output sample_word, input ready);
   modport sink (input valid, input command, input sample_word, output ready);
endinterface

interface pcmfade_rsp_if import pcmfade_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] dac_code;
   logic                 clip_done;

   modport source (output valid, output dac_code, output clip_done, input ready);
   modport sink (input valid, input dac_code, input clip_done, output ready);
endinterface

FILE: hdl/pcmfade_csr.sv
// pcmfade_csr: APB-style configuration registers of the fade-in streamer
// depends on pcmfade_pkg
module pcmfade_csr import pcmfade_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   // register write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FORMAT: cfg_in.sample_format = pwdata[0];
            REG_CLIP:   cfg_in.clip_samples  = pwdata[LEN_BITS-1:0];
            REG_FADE:   cfg_in.fade_samples  = pwdata[LEN_BITS-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      case (reg_idx)
         REG_FORMAT: prdata = DATA_BITS'(cfg_ff.sample_format);
         REG_CLIP:   prdata = DATA_BITS'(cfg_ff.clip_samples);
         REG_FADE:   prdata = DATA_BITS'(cfg_ff.fade_samples);
         default:    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/pcmfade_ctrl.sv
// pcmfade_ctrl: sequencer of the fade-in streamer, drives the datapath and the handshakes
// depends on pcmfade_pkg
module pcmfade_ctrl import pcmfade_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept, load;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid & req_ready;
   assign load      = (state_ff == S_OUT) & (~rsp_valid_ff | rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = stat.fade_go ? S_MUL : S_OUT;
            end
         end
         S_MUL: begin
            state_in = S_DIV;
            cnt_in   = '0;
         end
         S_DIV: begin
            if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
               state_in = S_FIX;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         S_FIX: state_in = S_OUT;
         S_OUT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register valid
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath commands
   assign cmd.accept   = accept;
   assign cmd.mul_go   = (state_ff == S_MUL);
   assign cmd.div_step = (state_ff == S_DIV);
   assign cmd.fix      = (state_ff == S_FIX);
   assign cmd.load_out = load;
   assign rsp_valid    = rsp_valid_ff;

endmodule

FILE: hdl/pcmfade_dp.sv
// pcmfade_dp: sample decode, position state, fade multiply and restoring divider
// depends on pcmfade_pkg
module pcmfade_dp import pcmfade_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic                 req_command,
   input  logic [WORD_BITS-1:0] req_sample_word,
   output logic [CODE_BITS-1:0] rsp_dac_code,
   output logic                 rsp_clip_done
);

   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic                 done_ff, done_in;
   logic [CODE_BITS-1:0] code_ff, code_in;
   logic                 neg_ff;
   logic [CODE_BITS-1:0] mag_ff;
   logic [LEN_BITS-1:0]  posm_ff;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [DVS_BITS-1:0]  dvs_ff, dvs_in;
   logic [CODE_BITS-1:0] quo_ff, quo_in;
   logic [CODE_BITS-1:0] out_code_ff;
   logic                 out_done_ff;

   logic [CODE_BITS-1:0] dec_code;
   logic [CODE_BITS-1:0] dec_mag;
   logic [CMP_BITS-1:0]  pos_x;
   logic                 in_clip, fade_on;
   logic [DIV_BITS-1:0]  div_x;
   logic                 div_ge;

   // sample decode
   always_comb begin
      if (cfg.sample_format == FMT_S16) begin
         dec_code = {~req_sample_word[15], req_sample_word[14:4]};
      end else begin
         dec_code = {req_sample_word[7:0], 4'b0000};
      end
      if (dec_code[CODE_BITS-1]) begin
         dec_mag = {1'b0, dec_code[CODE_BITS-2:0]};
      end else begin
         dec_mag = MID_CODE - dec_code;
      end
   end

   // clip and fade window checks
   assign pos_x   = CMP_BITS'(pos_ff);
   assign in_clip = pos_x < CMP_BITS'(cfg.clip_samples);
   assign fade_on = (cfg.fade_samples != '0) & (pos_x < CMP_BITS'(cfg.fade_samples));
   assign stat.fade_go = (req_command == CMD_NEXT) & in_clip & fade_on;

   // position, done flag and working code set on accept; code redone at fix-up
   always_comb begin
      pos_in  = pos_ff;
      done_in = done_ff;
      code_in = code_ff;
      if (cmd.accept) begin
         if (req_command == CMD_START) begin
            pos_in  = '0;
            done_in = 1'b0;
            code_in = MID_CODE;
         end else if (in_clip) begin
            pos_in  = pos_ff + POS_BITS'(1);
            code_in = dec_code;
         end else begin
            done_in = 1'b1;
            code_in = MID_CODE;
         end
      end else if (cmd.fix) begin
         code_in = neg_ff ? (MID_CODE - quo_ff) : (MID_CODE + quo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         done_ff <= done_in;
      end
   end

   // fade operands held from the accept cycle
   always_ff @(posedge clock) begin
      code_ff <= code_in;
      if (cmd.accept) begin
         neg_ff  <= ~dec_code[CODE_BITS-1];
         mag_ff  <= dec_mag;
         posm_ff <= LEN_BITS'(pos_ff);
      end
   end

   // multiply then one quotient bit per step
   assign div_x  = DIV_BITS'(dvs_ff);
   assign div_ge = rem_ff >= div_x;

   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      quo_in = quo_ff;
      if (cmd.mul_go) begin
         rem_in = DIV_BITS'(mag_ff) * DIV_BITS'(posm_ff);
         dvs_in = DVS_BITS'(cfg.fade_samples) << (DIV_STEPS - 1);
         quo_in = '0;
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = rem_ff - div_x;
         end
         dvs_in = dvs_ff >> 1;
         quo_in = {quo_ff[CODE_BITS-2:0], div_ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_code_ff <= code_ff;
         out_done_ff <= done_ff;
      end
   end

   assign rsp_dac_code  = out_code_ff;
   assign rsp_clip_done = out_done_ff;

endmodule

FILE: hdl/pcm_to_dac_fade_in_streamer.sv
// PCM sample to 12-bit DAC code streamer with linear fade-in. Each request item
// is a start command (answers mid-scale 2048, clears position and done) or a
// sample request (decodes the word, scales the swing about 2048 by
// position/fade while inside the fade window, answers 2048 and sets done past
// the clip end). One result item per request. A faded sample goes from accept
// through multiply, 12 steps of the restoring divider and fix-up to output
// load; any other item goes from accept straight to output load. A new item is
// taken only once the previous result sits in the output register, so items
// do not overlap. Registers must be written over the APB-style port only while
// the block is idle; the block does not enforce it. pready is always high.
// top level: instantiates pcmfade_csr, pcmfade_ctrl and pcmfade_dp
// depends on pcmfade_pkg and pcmfade_if
module pcm_to_dac_fade_in_streamer import pcmfade_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   pcmfade_req_if.sink          req_ch,
   pcmfade_rsp_if.source        rsp_ch,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   cfg_type     cfg;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // configuration registers
   pcmfade_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer
   pcmfade_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   pcmfade_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_ch.command),
      .req_sample_word (req_ch.sample_word),
      .rsp_dac_code    (rsp_ch.dac_code),
      .rsp_clip_done   (rsp_ch.clip_done)
   );

endmodule

FILE: hdl/pcmfade_checker.sv
// pcmfade_checker: port-level assertions of the fade-in streamer, bound to the top level
// depends on pcmfade_pkg and pcm_to_dac_fade_in_streamer
module pcmfade_checker import pcmfade_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CODE_BITS-1:0] rsp_dac_code,
   input logic                 rsp_clip_done
);

   logic [1:0] open_ff, open_in;

   // items taken but not yet delivered
   always_comb begin
      open_in = open_ff;
      if (req_valid & req_ready) begin
         open_in = open_in + 2'd1;
      end
      if (rsp_valid & rsp_ready) begin
         open_in = open_in - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dac_code) && $stable(rsp_clip_done))
      else $error("stalled result item changed");

   // no result without an item behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_ff != 2'd0)
      else $error("result item with no request outstanding");

   // at most one item in work and one in the output register
   a_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff == 2'd2 |-> !req_ready)
      else $error("request taken with two items outstanding");

   // output register empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind pcm_to_dac_fade_in_streamer pcmfade_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_dac_code  (rsp_ch.dac_code),
   .rsp_clip_done (rsp_ch.clip_done)
);
